/* rtl/core/skt_pkg.sv */
package skt_pkg;

   // Table geometry
   localparam int CAPACITY = 1024;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths of the transaction
   localparam int KEY_W  = 32;
   localparam int POS_W  = 10;
   localparam int ECNT_W = 11;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_CHK_RD,
      ST_CHK_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_STORE,
      ST_DONE
   } skt_state_type;

   // Controller to datapath
   typedef struct packed {
      logic ready;
      logic load_key;
      logic srch_read;
      logic srch_update;
      logic chk_read;
      logic chk_eval;
      logic shift_read;
      logic shift_write;
      logic store;
      logic out_load;
   } skt_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic srch_done;
      logic is_hit;
      logic has_room;
      logic shift_done;
      logic out_free;
   } skt_status_type;

endpackage

/* rtl/core/skt_ctrl.sv */
module skt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  skt_pkg::skt_status_type status,
   output skt_pkg::skt_cmd_type    cmd
);
   import skt_pkg::*;

   skt_state_type state_ff;
   skt_state_type state_in;

   // Advance the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            if (status.srch_done) begin
               state_in = ST_CHK_RD;
            end else begin
               state_in = ST_SRCH_CMP;
            end
         end
         ST_SRCH_CMP: begin
            state_in = ST_SRCH_RD;
         end
         ST_CHK_RD: begin
            state_in = ST_CHK_CMP;
         end
         ST_CHK_CMP: begin
            if (!status.is_hit && status.has_room) begin
               state_in = ST_SHIFT_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT_RD: begin
            if (status.shift_done) begin
               state_in = ST_STORE;
            end else begin
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            state_in = ST_SHIFT_RD;
         end
         ST_STORE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.ready    = 1'b1;
            cmd.load_key = req_valid;
         end
         ST_SRCH_RD: begin
            cmd.srch_read = !status.srch_done;
         end
         ST_SRCH_CMP: begin
            cmd.srch_update = 1'b1;
         end
         ST_CHK_RD: begin
            cmd.chk_read = 1'b1;
         end
         ST_CHK_CMP: begin
            cmd.chk_eval = 1'b1;
         end
         ST_SHIFT_RD: begin
            cmd.shift_read = !status.shift_done;
         end
         ST_SHIFT_WR: begin
            cmd.shift_write = 1'b1;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
         end
         ST_DONE: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* rtl/core/skt_dpath.sv */
module skt_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  skt_pkg::key_type             req_key,
   input  skt_pkg::skt_cmd_type         cmd,
   output skt_pkg::skt_status_type      status,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic                         rsp_inserted,
   output logic                         rsp_table_full,
   output logic [skt_pkg::POS_W-1:0]    rsp_position,
   output logic [skt_pkg::ECNT_W-1:0]   rsp_entry_count
);
   import skt_pkg::*;

   // Key store
   key_type mem [CAPACITY];

   key_type key_ff;
   key_type rdata_ff;
   cnt_type lo_ff;
   cnt_type hi_ff;
   cnt_type count_ff;
   cnt_type ptr_ff;
   logic    hit_ff;
   logic    full_ff;

   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic                rsp_ins_ff;
   logic                rsp_full_ff;
   logic [POS_W-1:0]    rsp_pos_ff;
   logic [ECNT_W-1:0]   rsp_cnt_ff;

   logic [CNT_W:0] mid_sum;
   cnt_type        mid;
   cnt_type        ptr_dec;
   idx_type        raddr;
   idx_type        waddr;
   key_type        wdata;
   logic           wen;
   logic           key_below;
   logic           hit_now;

   // Midpoint of the open search window
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[CNT_W:1];
   assign ptr_dec   = ptr_ff - cnt_type'(1);
   assign key_below = (rdata_ff < key_ff);
   assign hit_now   = (lo_ff < count_ff) && (rdata_ff == key_ff);

   // Pick the read address
   always_comb begin
      raddr = '0;
      if (cmd.srch_read) begin
         raddr = mid[IDX_W-1:0];
      end else if (cmd.chk_read) begin
         raddr = lo_ff[IDX_W-1:0];
      end else if (cmd.shift_read) begin
         raddr = ptr_dec[IDX_W-1:0];
      end
   end

   // Pick the write address and data
   always_comb begin
      wen   = cmd.shift_write || cmd.store;
      waddr = ptr_ff[IDX_W-1:0];
      wdata = rdata_ff;
      if (cmd.store) begin
         waddr = lo_ff[IDX_W-1:0];
         wdata = key_ff;
      end
   end

   // Memory port with registered read data
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
      if (wen) begin
         mem[waddr] <= wdata;
      end
   end

   // Search window, shift pointer and outcome
   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         key_ff <= req_key;
         lo_ff  <= '0;
         hi_ff  <= count_ff;
      end
      if (cmd.srch_update) begin
         if (key_below) begin
            lo_ff <= mid + cnt_type'(1);
         end else begin
            hi_ff <= mid;
         end
      end
      if (cmd.chk_eval) begin
         hit_ff  <= hit_now;
         full_ff <= !hit_now && (count_ff == cnt_type'(CAPACITY));
         ptr_ff  <= count_ff;
      end
      if (cmd.shift_write) begin
         ptr_ff <= ptr_dec;
      end
   end

   // Entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.store) begin
         count_ff <= count_ff + cnt_type'(1);
      end
   end

   // Hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_hit_ff  <= hit_ff;
         rsp_ins_ff  <= !hit_ff && !full_ff;
         rsp_full_ff <= full_ff;
         rsp_pos_ff  <= full_ff ? '0 : POS_W'(lo_ff);
         rsp_cnt_ff  <= ECNT_W'(count_ff);
      end
   end

   assign status.srch_done  = (lo_ff == hi_ff);
   assign status.is_hit     = hit_now;
   assign status.has_room   = (count_ff < cnt_type'(CAPACITY));
   assign status.shift_done = (ptr_ff == lo_ff);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_inserted    = rsp_ins_ff;
   assign rsp_table_full  = rsp_full_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_entry_count = rsp_cnt_ff;

   // The table never grows past its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(CAPACITY))
      else $error("entry count above capacity");

   // A result carries exactly one outcome
   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot({rsp_hit_ff, rsp_ins_ff, rsp_full_ff}))
      else $error("result outcome flags not one-hot");

   // A store adds exactly one entry
   a_store_count: assert property (@(posedge clock) disable iff (reset)
      cmd.store |=> (count_ff == $past(count_ff) + cnt_type'(1)))
      else $error("store did not add one entry");

   // The search window never inverts
   a_window: assert property (@(posedge clock) disable iff (reset)
      cmd.srch_update |=> (lo_ff <= hi_ff))
      else $error("search window inverted");

endmodule

/* rtl/core/sorted_key_table_lookup_insert.sv */
// Sorted key table: lookup with insert on miss.
//
// Input channel req_*: one 32-bit key per transaction, taken when req_valid
// is high and req_stall is low. The block raises req_stall while it works on
// a key and drops it once the result sits in the output register.
// Result channel rsp_*: one transaction per key with hit, inserted,
// table_full, position and entry_count, held until rsp_stall is low.
//
// Steps per key with n stored entries and insert position p:
//   accept the key; about log2(n+1) binary-search probes, each a read and
//   a compare, then close the search; a read and a compare for the final
//   check; on an insert move the n-p later entries up, each a read and a
//   write, end the move and store the key; then load the result. The key
//   memory has one registered read and one write per cycle, so every
//   probe and every moved entry is one read followed by one write or
//   compare.
// A stalled result does not block the next key: the block accepts it and
// works on it, and waits only to hand over its result.
// Reset empties the table and drops any pending result.
module sorted_key_table_lookup_insert (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  skt_pkg::key_type             req_key,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic                         rsp_inserted,
   output logic                         rsp_table_full,
   output logic [skt_pkg::POS_W-1:0]    rsp_position,
   output logic [skt_pkg::ECNT_W-1:0]   rsp_entry_count
);
   import skt_pkg::*;

   skt_cmd_type    cmd;
   skt_status_type status;

   // Sequence the search, shift and store
   skt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd)
   );

   // Key memory, search window and result register
   skt_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_key         (req_key),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_inserted    (rsp_inserted),
      .rsp_table_full  (rsp_table_full),
      .rsp_position    (rsp_position),
      .rsp_entry_count (rsp_entry_count)
   );

   // Take a new key only between transactions
   assign req_stall = !cmd.ready;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import skt_pkg::*;

   localparam int LONG_HOLD   = 300;
   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int MIXED_ITEMS = 100;
   localparam int FULL_ITEMS  = 60;
   localparam int DIR_COUNT   = 20;

   // One lookup outcome, laid out like the result ports
   typedef struct packed {
      logic               hit;
      logic               inserted;
      logic               table_full;
      logic [POS_W-1:0]   position;
      logic [ECNT_W-1:0]  entry_count;
   } lookup_result_type;

   // Directed row: key, whether the outcome is typed in, and that outcome
   typedef struct packed {
      key_type           key;
      logic              typed;
      lookup_result_type res;
   } vector_row_type;

   localparam lookup_result_type NO_RES = '0;

   localparam vector_row_type DIR_ROWS [DIR_COUNT] = '{
      // empty table: first key lands at position 0
      '{32'h8000_0000, 1'b1, '{1'b0, 1'b1, 1'b0, 10'd0, 11'd1}},
      '{32'h8000_0000, 1'b1, '{1'b1, 1'b0, 1'b0, 10'd0, 11'd1}},
      '{32'h0000_0000, 1'b1, '{1'b0, 1'b1, 1'b0, 10'd0, 11'd2}},
      '{32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b1, 1'b0, 10'd2, 11'd3}},
      // hit on the last entry must still report its position
      '{32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 1'b0, 10'd2, 11'd3}},
      '{32'h0000_0000, 1'b1, '{1'b1, 1'b0, 1'b0, 10'd0, 11'd3}},
      '{32'h0000_0001, 1'b0, NO_RES},
      '{32'hFFFF_FFFE, 1'b0, NO_RES},
      '{32'h7FFF_FFFF, 1'b0, NO_RES},
      '{32'h8000_0001, 1'b0, NO_RES},
      '{32'h5555_5555, 1'b0, NO_RES},
      '{32'hAAAA_AAAA, 1'b0, NO_RES},
      '{32'h7FFF_FFFF, 1'b0, NO_RES},
      '{32'h0000_FFFF, 1'b0, NO_RES},
      '{32'hFFFF_0000, 1'b0, NO_RES},
      '{32'h1234_5678, 1'b0, NO_RES},
      '{32'hFFFF_FFFE, 1'b0, NO_RES},
      '{32'h0000_0001, 1'b0, NO_RES},
      '{32'h8000_0000, 1'b0, NO_RES},
      '{32'hAAAA_AAAA, 1'b0, NO_RES}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   key_type             req_key;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_hit;
   logic                rsp_inserted;
   logic                rsp_table_full;
   logic [POS_W-1:0]    rsp_position;
   logic [ECNT_W-1:0]   rsp_entry_count;

   // Shadow copy of the sorted table
   key_type             shadow_keys [CAPACITY];
   int                  shadow_count;

   lookup_result_type   predicted_results [$];
   int                  error_count;
   int                  cycle_count;
   int                  tx_quiet;
   bit                  hold_request;

   sorted_key_table_lookup_insert dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_inserted    (rsp_inserted),
      .rsp_table_full  (rsp_table_full),
      .rsp_position    (rsp_position),
      .rsp_entry_count (rsp_entry_count)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Look up a key in the shadow table, insert on a miss when there is room
   function automatic lookup_result_type predict_lookup(input key_type k);
      lookup_result_type r;
      int p;
      int i;
      r = '0;
      p = 0;
      while (p < shadow_count && shadow_keys[p] < k)
         p++;
      if (p < shadow_count && shadow_keys[p] == k) begin
         r.hit      = 1'b1;
         r.position = p[POS_W-1:0];
      end else if (shadow_count < CAPACITY) begin
         for (i = shadow_count; i > p; i--)
            shadow_keys[i] = shadow_keys[i-1];
         shadow_keys[p] = k;
         shadow_count++;
         r.inserted = 1'b1;
         r.position = p[POS_W-1:0];
      end else begin
         r.table_full = 1'b1;
      end
      r.entry_count = shadow_count[ECNT_W-1:0];
      return r;
   endfunction

   // Queue an outcome behind the ones still expected
   function automatic void append_outcome(input lookup_result_type r);
      predicted_results = {predicted_results, r};
   endfunction

   // Idle length: mostly none or short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Sender gap, with occasional stretches of back-to-back transactions
   function automatic int next_gap();
      if (tx_quiet > 0) begin
         tx_quiet--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0)
         tx_quiet = 40;
      return idle_len();
   endfunction

   function automatic key_type rand_key();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return key_type'($urandom_range(0, 15));
      if (r == 1)
         return 32'hFFFF_FFF0 | key_type'($urandom_range(0, 15));
      return $urandom;
   endfunction

   function automatic key_type stored_key();
      if (shadow_count == 0)
         return $urandom;
      return shadow_keys[$urandom_range(0, shadow_count - 1)];
   endfunction

   // Present one key; record its outcome once the block takes it.
   // Called and returns at a falling edge, valid left high.
   task automatic offer_key(input key_type k, input int gap, input logic typed,
                            input lookup_result_type typed_res);
      lookup_result_type r;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_key   <= k;
      do @(posedge clock); while (req_stall);
      r = predict_lookup(k);
      append_outcome(typed ? typed_res : r);
      @(negedge clock);
   endtask

   // Drop valid and hold off until every outcome has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (predicted_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Compare each accepted result transaction with the oldest outcome
   always @(posedge clock) begin : rsp_check
      lookup_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_results.size() == 0) begin
            $display({"%0t: unexpected result: expected none, ",
                      "actual hit=%0b ins=%0b full=%0b pos=%0d cnt=%0d"},
                     $time, rsp_hit, rsp_inserted, rsp_table_full, rsp_position,
                     rsp_entry_count);
            error_count++;
         end else begin
            want = predicted_results.pop_front();
            check_field("hit", 32'(want.hit), 32'(rsp_hit));
            check_field("inserted", 32'(want.inserted), 32'(rsp_inserted));
            check_field("table_full", 32'(want.table_full), 32'(rsp_table_full));
            check_field("position", 32'(want.position), 32'(rsp_position));
            check_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Receiver: random stalls, quiet stretches, and one long hold on request
   initial begin : rsp_side
      int stall_left;
      int free_left;
      stall_left = 0;
      free_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (free_left > 0) begin
               free_left--;
            end else begin
               free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(0, 8);
               stall_left = idle_len();
            end
         end
      end
   end

   // Sender: directed rows, mixed keys, fill to capacity, then a full table
   initial begin : req_side
      int n;
      int r;
      key_type fill_key;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_key      = '0;
      hold_request = 1'b0;
      tx_quiet     = 0;
      error_count  = 0;
      cycle_count  = 0;
      shadow_count = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table
      for (n = 0; n < DIR_COUNT; n++)
         offer_key(DIR_ROWS[n].key, next_gap(), DIR_ROWS[n].typed, DIR_ROWS[n].res);
      drain();

      // Mixed hits, near misses and fresh keys while the table is small
      for (n = 0; n < MIXED_ITEMS; n++) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            offer_key(stored_key(), next_gap(), 1'b0, NO_RES);
         else if (r < 50)
            offer_key(stored_key() + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF),
                      next_gap(), 1'b0, NO_RES);
         else
            offer_key(rand_key(), next_gap(), 1'b0, NO_RES);
      end
      drain();

      // Fill to capacity, mostly with rising keys to keep shifts short
      fill_key = 32'hF000_0000;
      n = 0;
      while (shadow_count < CAPACITY) begin
         if (n == 20)
            hold_request = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 90) begin
            fill_key = fill_key + key_type'($urandom_range(1, 32'h8000));
            offer_key(fill_key, next_gap(), 1'b0, NO_RES);
         end else if (r < 96) begin
            offer_key(stored_key(), next_gap(), 1'b0, NO_RES);
         end else begin
            offer_key(rand_key(), next_gap(), 1'b0, NO_RES);
         end
         n++;
      end

      // Full table: hits and rejected absent keys
      offer_key(32'h0000_0000, next_gap(), 1'b0, NO_RES);
      offer_key(32'hFFFF_FFFF, next_gap(), 1'b0, NO_RES);
      for (n = 0; n < FULL_ITEMS; n++) begin
         if ($urandom_range(0, 1))
            offer_key(stored_key(), next_gap(), 1'b0, NO_RES);
         else
            offer_key(rand_key(), next_gap(), 1'b0, NO_RES);
      end
      drain();

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
